### hw/rtl/qpdbs_pkg.sv
// ----------------------------------------------------------------------------
// qpdbs_pkg
// Shared widths, register indexes and the quarter-wave sine generator for
// the quadratic-phase dechirp block integrator.
// ----------------------------------------------------------------------------
`default_nettype none

package qpdbs_pkg;

   localparam int SAMPLE_W    = 16;
   localparam int MAG_W       = SAMPLE_W - 1;
   localparam int PHASE_W     = 33;
   localparam int SINE_ADDR_W = 10;
   localparam int ROT_W       = SAMPLE_W + 1;
   localparam int PROD_W      = 2 * ROT_W;
   localparam int SUM_W       = 29;
   localparam int POWER_W     = 48;
   localparam int RATE_W      = 32;
   localparam int START_W     = 31;
   localparam int SPB_W       = 13;
   localparam int BCNT_W      = 16;

   localparam int CSR_ADDR_W  = 3;
   localparam int CSR_DATA_W  = 32;
   localparam int REQ_DATA_W  = 2 * SAMPLE_W;
   localparam int RSP_DATA_W  = 112;

   localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_SHIFT_RATE   = 3'd0,
      CSR_DRIFT_RATE   = 3'd1,
      CSR_START_INDEX  = 3'd2,
      CSR_BLOCK_LEN    = 3'd3,
      CSR_BLOCK_COUNT  = 3'd4
   } csr_index_type;

   // sin(pi/2 * j / quarter) in Q1.15 from a Q30 Taylor series, elaboration only
   function automatic logic [MAG_W-1:0] quarter_sine(int j);
      longint unsigned t;
      longint unsigned t2;
      longint unsigned r;
      longint unsigned s;
      t  = (64'(unsigned'(j)) * HALF_PI_Q30) >> (SINE_ADDR_W - 2);
      t2 = (t * t) >> 30;
      r  = 64'd1 << 30;
      r  = (64'd1 << 30) - ((t2 * r) >> 30) / 64'd156;
      r  = (64'd1 << 30) - ((t2 * r) >> 30) / 64'd110;
      r  = (64'd1 << 30) - ((t2 * r) >> 30) / 64'd72;
      r  = (64'd1 << 30) - ((t2 * r) >> 30) / 64'd42;
      r  = (64'd1 << 30) - ((t2 * r) >> 30) / 64'd20;
      r  = (64'd1 << 30) - ((t2 * r) >> 30) / 64'd6;
      s  = (t * r) >> 30;
      s  = (s + 64'd16384) >> 15;
      if (s > 64'd32767) begin
         s = 64'd32767;
      end
      return s[MAG_W-1:0];
   endfunction

endpackage

`default_nettype wire

### hw/rtl/qpdbs_sine_rom.sv
// ----------------------------------------------------------------------------
// qpdbs_sine_rom
// Full-circle sine lookup built from a quarter-wave table, registered output.
// ----------------------------------------------------------------------------
`default_nettype none

module qpdbs_sine_rom (
   input  logic                                    clock,
   input  logic [qpdbs_pkg::SINE_ADDR_W-1:0]       rom_addr,
   output logic signed [qpdbs_pkg::SAMPLE_W-1:0]   rom_q
);

   localparam int QTR_N = 2 ** (qpdbs_pkg::SINE_ADDR_W - 2);
   localparam int IDX_W = qpdbs_pkg::SINE_ADDR_W - 1;

   logic [qpdbs_pkg::MAG_W-1:0]           qtab [0:QTR_N];
   logic [1:0]                            quad;
   logic [qpdbs_pkg::SINE_ADDR_W-3:0]     off;
   logic [IDX_W-1:0]                      idx;
   logic signed [qpdbs_pkg::SAMPLE_W-1:0] mag_s;
   logic signed [qpdbs_pkg::SAMPLE_W-1:0] rom_q_in;
   logic signed [qpdbs_pkg::SAMPLE_W-1:0] rom_q_ff;

   for (genvar g = 0; g <= QTR_N; g++) begin : g_tab
      localparam logic [qpdbs_pkg::MAG_W-1:0] ENTRY = qpdbs_pkg::quarter_sine(g);
      assign qtab[g] = ENTRY;
   end

   always_comb begin
      quad  = rom_addr[qpdbs_pkg::SINE_ADDR_W-1 -: 2];
      off   = rom_addr[qpdbs_pkg::SINE_ADDR_W-3:0];
      if (quad[0]) begin
         idx = IDX_W'(QTR_N) - {1'b0, off};
      end else begin
         idx = {1'b0, off};
      end
      mag_s = {1'b0, qtab[idx]};
      if (quad[1]) begin
         rom_q_in = -mag_s;
      end else begin
         rom_q_in = mag_s;
      end
   end

   always_ff @(posedge clock) begin
      rom_q_ff <= rom_q_in;
   end

   assign rom_q = rom_q_ff;

endmodule

`default_nettype wire

### hw/rtl/quadratic_phase_dechirp_block_sum_core.sv
// ----------------------------------------------------------------------------
// quadratic_phase_dechirp_block_sum_core
// Quadratic-phase dechirp of complex samples with per-block coherent sums.
// ----------------------------------------------------------------------------
// Each request carries one complex sample. The block rotates it by the
// quadratic phase of its absolute index, adds it to the block sum and to the
// saturating run power, and sends one response at every block end. Until
// the next acceptance a sample passes through sine/cosine lookup, six
// products through a single 17x17 multiplier, an accumulate step and a
// commit step; the first of a run is preceded by a bit-serial phase load
// from start_index. A finished response waits in its own register, so new
// requests are taken while it is pending; a further block end stalls the
// commit step. CSR writes are taken every cycle; defined indexes end the run.
// ----------------------------------------------------------------------------
`default_nettype none

module quadratic_phase_dechirp_block_sum_core #(
   parameter int MAX_BLOCK_SAMPLES = 4096
) (
   input  logic                                clock,
   input  logic                                reset,

   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [qpdbs_pkg::CSR_ADDR_W-1:0]    csr_addr,
   input  logic [qpdbs_pkg::CSR_DATA_W-1:0]    csr_wdata,

   input  logic                                req_tvalid,
   output logic                                req_tready,
   // [15:0] sample_re, [31:16] sample_im
   input  logic [qpdbs_pkg::REQ_DATA_W-1:0]    req_tdata,

   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // [28:0] block_sum_re, [57:29] block_sum_im, [105:58] power_total, zero pad
   output logic [qpdbs_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   // run_done
   output logic                                rsp_tlast
);

   localparam int CNT_W  = $clog2(MAX_BLOCK_SAMPLES + 1);
   localparam int ACC_W  = 31;
   localparam int PW_W   = qpdbs_pkg::PROD_W;
   localparam int K_MSB  = qpdbs_pkg::START_W - 1;
   localparam int BIT_W  = $clog2(qpdbs_pkg::START_W);
   localparam int PAD_W  = qpdbs_pkg::RSP_DATA_W - 2 * qpdbs_pkg::SUM_W - qpdbs_pkg::POWER_W;
   localparam int PW_SUM_W = qpdbs_pkg::POWER_W + 1;
   localparam int RSH    = qpdbs_pkg::SAMPLE_W - 1;

   localparam logic signed [ACC_W-1:0] SUM_HI = ACC_W'(2 ** (qpdbs_pkg::SUM_W - 1) - 1);
   localparam logic signed [ACC_W-1:0] SUM_LO = -ACC_W'(2 ** (qpdbs_pkg::SUM_W - 1));
   localparam logic signed [qpdbs_pkg::PROD_W-1:0] ROUND_HALF = qpdbs_pkg::PROD_W'(1) << (RSH - 1);
   localparam logic [qpdbs_pkg::PHASE_W-1:0] ADDR_ROUND =
      qpdbs_pkg::PHASE_W'(1) << (qpdbs_pkg::PHASE_W - 1 - qpdbs_pkg::SINE_ADDR_W);
   localparam logic [qpdbs_pkg::SINE_ADDR_W-1:0] COS_OFFSET =
      qpdbs_pkg::SINE_ADDR_W'(2 ** (qpdbs_pkg::SINE_ADDR_W - 2));

   typedef enum logic [6:0] {
      ST_IDLE = 7'b0000001,
      ST_INIT = 7'b0000010,
      ST_LOAD = 7'b0000100,
      ST_SIN  = 7'b0001000,
      ST_COS  = 7'b0010000,
      ST_MUL  = 7'b0100000,
      ST_FIN  = 7'b1000000
   } state_type;

   typedef enum logic [2:0] {
      MS_Y_SN   = 3'd0,
      MS_X_CS   = 3'd1,
      MS_Y_CS   = 3'd2,
      MS_X_SN   = 3'd3,
      MS_RE_SQ  = 3'd4,
      MS_IM_SQ  = 3'd5,
      MS_PW_ADD = 3'd6
   } mul_step_type;

   function automatic logic [qpdbs_pkg::SUM_W-1:0] clamp_sum(logic signed [ACC_W-1:0] v);
      logic signed [ACC_W-1:0] c;
      if (v > SUM_HI) begin
         c = SUM_HI;
      end else if (v < SUM_LO) begin
         c = SUM_LO;
      end else begin
         c = v;
      end
      return c[qpdbs_pkg::SUM_W-1:0];
   endfunction

   state_type    state_ff, state_in;
   mul_step_type step_ff, step_in;

   logic [qpdbs_pkg::RATE_W-1:0]  shift_rate_ff, shift_rate_in;
   logic [qpdbs_pkg::RATE_W-1:0]  drift_rate_ff, drift_rate_in;
   logic [qpdbs_pkg::START_W-1:0] start_index_ff, start_index_in;
   logic [qpdbs_pkg::SPB_W-1:0]   block_len_ff, block_len_in;
   logic [qpdbs_pkg::BCNT_W-1:0]  block_count_ff, block_count_in;
   logic                          run_active_ff, run_active_in;

   logic signed [qpdbs_pkg::SAMPLE_W-1:0] x_ff, x_in, y_ff, y_in;
   logic signed [qpdbs_pkg::SAMPLE_W-1:0] sn_ff, sn_in, cs_ff, cs_in;
   logic [qpdbs_pkg::PHASE_W-1:0] phase_acc_ff, phase_acc_in;
   logic [qpdbs_pkg::PHASE_W-1:0] phase_step_ff, phase_step_in;
   logic [qpdbs_pkg::PHASE_W-1:0] sk_ff, sk_in, dk_ff, dk_in, dkk_ff, dkk_in;
   logic [BIT_W-1:0]              bit_ff, bit_in;

   logic signed [qpdbs_pkg::PROD_W-1:0] prod_ff;
   logic signed [qpdbs_pkg::PROD_W-1:0] t_re_ff, t_re_in, t_im_ff, t_im_in;
   logic [PW_W-1:0]                     pw_ff, pw_in;
   logic signed [ACC_W-1:0]             acc_re_ff, acc_re_in, acc_im_ff, acc_im_in;
   logic [qpdbs_pkg::POWER_W-1:0]       power_ff, power_in;
   logic [CNT_W-1:0]                    cnt_ff, cnt_in;
   logic [qpdbs_pkg::BCNT_W-1:0]        blk_ff, blk_in;

   logic                                rsp_valid_ff, rsp_valid_in;
   logic [qpdbs_pkg::RSP_DATA_W-1:0]    rsp_data_ff, rsp_data_in;
   logic                                rsp_last_ff, rsp_last_in;

   logic signed [qpdbs_pkg::ROT_W-1:0]  mul_a, mul_b, re_v, im_v;
   logic signed [qpdbs_pkg::PROD_W-1:0] mul_p;
   logic [qpdbs_pkg::PHASE_W-1:0]       s33, d33, phase_rnd;
   logic [qpdbs_pkg::SINE_ADDR_W-1:0]   sin_addr, rom_addr;
   logic signed [qpdbs_pkg::SAMPLE_W-1:0] rom_q;
   logic [31:0]                         spb_wide, lim_wide;
   logic [CNT_W-1:0]                    limit, cnt_next;
   logic [qpdbs_pkg::BCNT_W-1:0]        bc_lim, blk_next;
   logic                                block_end, run_last, kbit;
   logic signed [ACC_W-1:0]             sum_re, sum_im;
   logic [PW_SUM_W-1:0]                 power_sum;
   logic [qpdbs_pkg::POWER_W-1:0]       power_sat;

   qpdbs_sine_rom u_sine_rom (
      .clock    (clock),
      .rom_addr (rom_addr),
      .rom_q    (rom_q)
   );

   assign s33       = {shift_rate_ff[qpdbs_pkg::RATE_W-1], shift_rate_ff};
   assign d33       = {drift_rate_ff[qpdbs_pkg::RATE_W-1], drift_rate_ff};
   assign phase_rnd = phase_acc_ff + ADDR_ROUND;
   assign sin_addr  = phase_rnd[qpdbs_pkg::PHASE_W-1 -: qpdbs_pkg::SINE_ADDR_W];
   assign rom_addr  = (state_ff == ST_COS) ? sin_addr + COS_OFFSET : sin_addr;
   assign kbit      = start_index_ff[bit_ff];

   assign re_v = t_re_ff[RSH + qpdbs_pkg::ROT_W - 1 : RSH];
   assign im_v = t_im_ff[RSH + qpdbs_pkg::ROT_W - 1 : RSH];

   always_comb begin
      case (step_ff)
         MS_Y_SN: begin
            mul_a = qpdbs_pkg::ROT_W'(y_ff);
            mul_b = qpdbs_pkg::ROT_W'(sn_ff);
         end
         MS_X_CS: begin
            mul_a = qpdbs_pkg::ROT_W'(x_ff);
            mul_b = qpdbs_pkg::ROT_W'(cs_ff);
         end
         MS_Y_CS: begin
            mul_a = qpdbs_pkg::ROT_W'(y_ff);
            mul_b = qpdbs_pkg::ROT_W'(cs_ff);
         end
         MS_X_SN: begin
            mul_a = qpdbs_pkg::ROT_W'(x_ff);
            mul_b = qpdbs_pkg::ROT_W'(sn_ff);
         end
         MS_RE_SQ: begin
            mul_a = re_v;
            mul_b = re_v;
         end
         MS_IM_SQ: begin
            mul_a = im_v;
            mul_b = im_v;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign mul_p = mul_a * mul_b;

   always_comb begin
      spb_wide = 32'(block_len_ff);
      if (spb_wide == 32'd0) begin
         lim_wide = 32'd1;
      end else if (spb_wide > 32'(MAX_BLOCK_SAMPLES)) begin
         lim_wide = 32'(MAX_BLOCK_SAMPLES);
      end else begin
         lim_wide = spb_wide;
      end
   end

   assign limit     = lim_wide[CNT_W-1:0];
   assign cnt_next  = cnt_ff + CNT_W'(1);
   assign block_end = (cnt_next >= limit);
   assign bc_lim    = (block_count_ff == '0) ? qpdbs_pkg::BCNT_W'(1) : block_count_ff;
   assign blk_next  = blk_ff + qpdbs_pkg::BCNT_W'(1);
   assign run_last  = (blk_next >= bc_lim);
   assign sum_re    = acc_re_ff + ACC_W'(re_v);
   assign sum_im    = acc_im_ff + ACC_W'(im_v);
   assign power_sum = PW_SUM_W'(power_ff) + PW_SUM_W'(pw_ff);
   assign power_sat = power_sum[PW_SUM_W-1] ? '1 : power_sum[qpdbs_pkg::POWER_W-1:0];

   always_comb begin
      state_in       = state_ff;
      step_in        = step_ff;
      shift_rate_in  = shift_rate_ff;
      drift_rate_in  = drift_rate_ff;
      start_index_in = start_index_ff;
      block_len_in   = block_len_ff;
      block_count_in = block_count_ff;
      run_active_in  = run_active_ff;
      x_in           = x_ff;
      y_in           = y_ff;
      sn_in          = sn_ff;
      cs_in          = cs_ff;
      phase_acc_in   = phase_acc_ff;
      phase_step_in  = phase_step_ff;
      sk_in          = sk_ff;
      dk_in          = dk_ff;
      dkk_in         = dkk_ff;
      bit_in         = bit_ff;
      t_re_in        = t_re_ff;
      t_im_in        = t_im_ff;
      pw_in          = pw_ff;
      acc_re_in      = acc_re_ff;
      acc_im_in      = acc_im_ff;
      power_in       = power_ff;
      cnt_in         = cnt_ff;
      blk_in         = blk_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_tready;
      rsp_data_in    = rsp_data_ff;
      rsp_last_in    = rsp_last_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               x_in = req_tdata[qpdbs_pkg::SAMPLE_W-1:0];
               y_in = req_tdata[qpdbs_pkg::REQ_DATA_W-1:qpdbs_pkg::SAMPLE_W];
               if (run_active_ff) begin
                  state_in = ST_SIN;
               end else begin
                  sk_in    = '0;
                  dk_in    = '0;
                  dkk_in   = '0;
                  bit_in   = BIT_W'(K_MSB);
                  state_in = ST_INIT;
               end
            end
         end
         ST_INIT: begin
            // k is shifted in MSB first: s*k, d*k and d*k*k follow by shift-add
            sk_in  = (sk_ff << 1) + (kbit ? s33 : '0);
            dk_in  = (dk_ff << 1) + (kbit ? d33 : '0);
            dkk_in = (dkk_ff << 2) + (kbit ? ((dk_ff << 2) + d33) : '0);
            bit_in = bit_ff - BIT_W'(1);
            if (bit_ff == '0) begin
               state_in = ST_LOAD;
            end
         end
         ST_LOAD: begin
            phase_acc_in  = (sk_ff << 1) + dkk_ff;
            phase_step_in = (s33 << 1) + (dk_ff << 1) + d33;
            acc_re_in     = '0;
            acc_im_in     = '0;
            power_in      = '0;
            cnt_in        = '0;
            blk_in        = '0;
            run_active_in = 1'b1;
            state_in      = ST_SIN;
         end
         ST_SIN: begin
            state_in = ST_COS;
         end
         ST_COS: begin
            sn_in    = rom_q;
            step_in  = MS_Y_SN;
            state_in = ST_MUL;
         end
         ST_MUL: begin
            step_in = mul_step_type'(step_ff + 3'd1);
            case (step_ff)
               MS_Y_SN:   cs_in   = rom_q;
               MS_X_CS:   t_re_in = prod_ff + ROUND_HALF;
               MS_Y_CS:   t_re_in = t_re_ff + prod_ff;
               MS_X_SN:   t_im_in = prod_ff + ROUND_HALF;
               MS_RE_SQ:  t_im_in = t_im_ff - prod_ff;
               MS_IM_SQ:  pw_in   = PW_W'(unsigned'(prod_ff));
               MS_PW_ADD: begin
                  pw_in    = pw_ff + PW_W'(unsigned'(prod_ff));
                  state_in = ST_FIN;
               end
               default: state_in = ST_FIN;
            endcase
         end
         ST_FIN: begin
            if (!(block_end && rsp_valid_ff && !rsp_tready)) begin
               power_in      = power_sat;
               phase_acc_in  = phase_acc_ff + phase_step_ff;
               phase_step_in = phase_step_ff + (d33 << 1);
               state_in      = ST_IDLE;
               if (block_end) begin
                  acc_re_in    = '0;
                  acc_im_in    = '0;
                  cnt_in       = '0;
                  blk_in       = blk_next;
                  rsp_valid_in = 1'b1;
                  rsp_last_in  = run_last;
                  rsp_data_in  = {PAD_W'(0), power_sat, clamp_sum(sum_im), clamp_sum(sum_re)};
                  if (run_last) begin
                     run_active_in = 1'b0;
                  end
               end else begin
                  acc_re_in = sum_re;
                  acc_im_in = sum_im;
                  cnt_in    = cnt_next;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase

      if (csr_valid) begin
         unique case (csr_addr)
            qpdbs_pkg::CSR_SHIFT_RATE: begin
               shift_rate_in = csr_wdata[qpdbs_pkg::RATE_W-1:0];
               run_active_in = 1'b0;
            end
            qpdbs_pkg::CSR_DRIFT_RATE: begin
               drift_rate_in = csr_wdata[qpdbs_pkg::RATE_W-1:0];
               run_active_in = 1'b0;
            end
            qpdbs_pkg::CSR_START_INDEX: begin
               start_index_in = csr_wdata[qpdbs_pkg::START_W-1:0];
               run_active_in  = 1'b0;
            end
            qpdbs_pkg::CSR_BLOCK_LEN: begin
               block_len_in  = csr_wdata[qpdbs_pkg::SPB_W-1:0];
               run_active_in = 1'b0;
            end
            qpdbs_pkg::CSR_BLOCK_COUNT: begin
               block_count_in = csr_wdata[qpdbs_pkg::BCNT_W-1:0];
               run_active_in  = 1'b0;
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         step_ff        <= MS_Y_SN;
         shift_rate_ff  <= '0;
         drift_rate_ff  <= '0;
         start_index_ff <= '0;
         block_len_ff   <= qpdbs_pkg::SPB_W'(1024);
         block_count_ff <= qpdbs_pkg::BCNT_W'(1);
         run_active_ff  <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         step_ff        <= step_in;
         shift_rate_ff  <= shift_rate_in;
         drift_rate_ff  <= drift_rate_in;
         start_index_ff <= start_index_in;
         block_len_ff   <= block_len_in;
         block_count_ff <= block_count_in;
         run_active_ff  <= run_active_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff          <= x_in;
      y_ff          <= y_in;
      sn_ff         <= sn_in;
      cs_ff         <= cs_in;
      phase_acc_ff  <= phase_acc_in;
      phase_step_ff <= phase_step_in;
      sk_ff         <= sk_in;
      dk_ff         <= dk_in;
      dkk_ff        <= dkk_in;
      bit_ff        <= bit_in;
      prod_ff       <= mul_p;
      t_re_ff       <= t_re_in;
      t_im_ff       <= t_im_in;
      pw_ff         <= pw_in;
      acc_re_ff     <= acc_re_in;
      acc_im_ff     <= acc_im_in;
      power_ff      <= power_in;
      cnt_ff        <= cnt_in;
      blk_ff        <= blk_in;
      rsp_data_ff   <= rsp_data_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign csr_ready  = 1'b1;
   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

`default_nettype wire

### hw/rtl/qpdbs_checker.sv
// ----------------------------------------------------------------------------
// qpdbs_checker
// Port-level checks for the dechirp block integrator, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module qpdbs_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                csr_valid,
   input logic                                csr_ready,
   input logic [qpdbs_pkg::CSR_ADDR_W-1:0]    csr_addr,
   input logic [qpdbs_pkg::CSR_DATA_W-1:0]    csr_wdata,
   input logic                                req_tvalid,
   input logic                                req_tready,
   input logic [qpdbs_pkg::REQ_DATA_W-1:0]    req_tdata,
   input logic                                rsp_tvalid,
   input logic                                rsp_tready,
   input logic [qpdbs_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   input logic                                rsp_tlast
);

   localparam int PAD_LSB = 2 * qpdbs_pkg::SUM_W + qpdbs_pkg::POWER_W;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("response changed while stalled");

   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request taken while previous one in work");

   a_rsp_pad: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[qpdbs_pkg::RSP_DATA_W-1:PAD_LSB] == '0)
      else $error("response pad bits not zero");

   a_rsp_from_work: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(!req_tready))
      else $error("response appeared without a request in work");

endmodule

bind quadratic_phase_dechirp_block_sum_core qpdbs_checker u_qpdbs_checker (.*);

`default_nettype wire

### verif/tb_quadratic_phase_dechirp_block_sum_core.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_quadratic_phase_dechirp_block_sum_core
// Self-checking bench for the quadratic-phase dechirp block integrator.
// ----------------------------------------------------------------------------
// Each accepted sample request is rotated by a bit-exact copy of the phase
// accumulator, sine table and rounding of the block, and every block end
// queues the expected sums, run power and run_done flag. Responses are
// checked field by field in order. Directed cases cover the sample extremes,
// zero block length and count, aborted runs and writes to an unused index.
// Random segments change the registers between drained phases under varying
// source and sink back-pressure. A final long run drives the power total
// into saturation with an oversized block length.
// ----------------------------------------------------------------------------

module tb_quadratic_phase_dechirp_block_sum_core;

   import qpdbs_pkg::*;

   localparam int MAX_BLOCK   = 4096;
   localparam int ROM_SIZE    = 1 << SINE_ADDR_W;
   localparam int QUARTER_ROM = ROM_SIZE / 4;
   localparam int RUN_LATENCY = 64;
   localparam int RANDOM_REQS = 1000;
   localparam int SAT_BLOCKS  = 33;
   localparam logic [CSR_ADDR_W-1:0] CSR_UNUSED_INDEX = 3'd7;
   localparam longint SUM_HI  = (longint'(1) << (SUM_W - 1)) - 1;
   localparam longint SUM_LO  = -SUM_HI - 1;
   localparam longint unsigned POWER_FULL = (64'd1 << POWER_W) - 1;

   typedef struct {
      logic [SUM_W-1:0]   sum_re;
      logic [SUM_W-1:0]   sum_im;
      logic [POWER_W-1:0] power;
      logic               last;
   } block_sum_t;

   class dechirp_integrator;
      logic [RATE_W-1:0]  shift_rate;
      logic [RATE_W-1:0]  drift_rate;
      logic [START_W-1:0] start_index;
      logic [SPB_W-1:0]   block_len;
      logic [BCNT_W-1:0]  block_count;
      logic [PHASE_W-1:0] phase_acc;
      logic [PHASE_W-1:0] phase_step;
      longint             acc_re;
      longint             acc_im;
      longint unsigned    power_acc;
      int                 in_block;
      int                 blocks_done;
      bit                 run_active;
      int                 sine_rom[ROM_SIZE];
      block_sum_t         pending_sums[$];
      int                 failures;
      int                 reported;

      function longint quarter_wave(int j);
         longint unsigned divs[6] = '{64'd156, 64'd110, 64'd72, 64'd42, 64'd20, 64'd6};
         longint unsigned t, t2, r, v;
         t  = (64'(j) * HALF_PI_Q30) >> (SINE_ADDR_W - 2);
         t2 = (t * t) >> 30;
         r  = 64'd1 << 30;
         foreach (divs[i]) begin
            r = (64'd1 << 30) - ((t2 * r) >> 30) / divs[i];
         end
         v = (t * r) >> 30;
         v = (v + 64'd16384) >> 15;
         if (v > 64'd32767) begin
            v = 64'd32767;
         end
         return longint'(v);
      endfunction

      function void power_on();
         int quad, off;
         shift_rate  = '0;
         drift_rate  = '0;
         start_index = '0;
         block_len   = 13'd1024;
         block_count = 16'd1;
         run_active  = 1'b0;
         for (int a = 0; a < ROM_SIZE; a++) begin
            quad = a / QUARTER_ROM;
            off  = a % QUARTER_ROM;
            case (quad)
               0:       sine_rom[a] = quarter_wave(off);
               1:       sine_rom[a] = quarter_wave(QUARTER_ROM - off);
               2:       sine_rom[a] = -quarter_wave(off);
               default: sine_rom[a] = -quarter_wave(QUARTER_ROM - off);
            endcase
         end
      endfunction

      function int eff_block_len();
         if (block_len == 0) return 1;
         if (block_len > MAX_BLOCK) return MAX_BLOCK;
         return block_len;
      endfunction

      function int eff_block_count();
         return (block_count == 0) ? 1 : block_count;
      endfunction

      function longint clamp_sum(longint v);
         if (v > SUM_HI) return SUM_HI;
         if (v < SUM_LO) return SUM_LO;
         return v;
      endfunction

      // any write to a defined register drops the run in progress
      function void write_reg(logic [CSR_ADDR_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
         case (idx)
            CSR_SHIFT_RATE:  shift_rate  = data;
            CSR_DRIFT_RATE:  drift_rate  = data;
            CSR_START_INDEX: start_index = data[START_W-1:0];
            CSR_BLOCK_LEN:   block_len   = data[SPB_W-1:0];
            CSR_BLOCK_COUNT: block_count = data[BCNT_W-1:0];
            default:         return;
         endcase
         run_active = 1'b0;
      endfunction

      function void take_sample(logic [SAMPLE_W-1:0] re_in, logic [SAMPLE_W-1:0] im_in);
         longint unsigned s, d, k, rounded, pw;
         longint x, y, c, sn, re, im;
         int addr;
         block_sum_t sum;
         s = {{32{shift_rate[RATE_W-1]}}, shift_rate};
         d = {{32{drift_rate[RATE_W-1]}}, drift_rate};
         if (!run_active) begin
            k           = start_index;
            phase_acc   = PHASE_W'(2 * s * k + d * k * k);
            phase_step  = PHASE_W'(2 * s + d * (2 * k + 1));
            acc_re      = 0;
            acc_im      = 0;
            power_acc   = 0;
            in_block    = 0;
            blocks_done = 0;
            run_active  = 1'b1;
         end
         x = $signed(re_in);
         y = $signed(im_in);
         rounded = 64'(phase_acc) + (64'd1 << (PHASE_W - 1 - SINE_ADDR_W));
         addr = int'(rounded >> (PHASE_W - SINE_ADDR_W)) & (ROM_SIZE - 1);
         sn = sine_rom[addr];
         c  = sine_rom[(addr + QUARTER_ROM) & (ROM_SIZE - 1)];
         re = (x * c + y * sn + 16384) >>> 15;
         im = (y * c - x * sn + 16384) >>> 15;
         acc_re += re;
         acc_im += im;
         pw = re * re + im * im;
         power_acc = (POWER_FULL - power_acc < pw) ? POWER_FULL : power_acc + pw;
         phase_acc  = PHASE_W'(phase_acc + phase_step);
         phase_step = PHASE_W'(phase_step + 2 * d);
         in_block++;
         if (in_block < eff_block_len()) return;
         blocks_done++;
         sum.sum_re = SUM_W'(clamp_sum(acc_re));
         sum.sum_im = SUM_W'(clamp_sum(acc_im));
         sum.power  = power_acc[POWER_W-1:0];
         sum.last   = (blocks_done >= eff_block_count());
         pending_sums.push_back(sum);
         acc_re   = 0;
         acc_im   = 0;
         in_block = 0;
         if (sum.last) run_active = 1'b0;
      endfunction

      function void compare_field(string field, logic [63:0] want, logic [63:0] got);
         if (want !== got) begin
            failures++;
            if (reported < 10) begin
               $display("%0t: %s mismatch: expected %h, got %h", $realtime, field, want, got);
               reported++;
            end
         end
      endfunction

      function void match_block_sum(logic [RSP_DATA_W-1:0] tdata, logic tlast);
         block_sum_t want;
         if (pending_sums.size() == 0) begin
            failures++;
            if (reported < 10) begin
               $display("%0t: block sum %h with no request outstanding", $realtime, tdata);
               reported++;
            end
            return;
         end
         want = pending_sums.pop_front();
         compare_field("block_sum_re", want.sum_re, tdata[SUM_W-1:0]);
         compare_field("block_sum_im", want.sum_im, tdata[2*SUM_W-1:SUM_W]);
         compare_field("power_total", want.power, tdata[2*SUM_W+POWER_W-1:2*SUM_W]);
         compare_field("tdata pad", '0, tdata[RSP_DATA_W-1:2*SUM_W+POWER_W]);
         compare_field("run_done", want.last, tlast);
      endfunction
   endclass

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    csr_valid = 1'b0;
   logic                    csr_ready;
   logic [CSR_ADDR_W-1:0]   csr_addr = '0;
   logic [CSR_DATA_W-1:0]   csr_wdata = '0;
   logic                    req_tvalid = 1'b0;
   logic                    req_tready;
   logic [REQ_DATA_W-1:0]   req_tdata = '0;
   logic                    rsp_tvalid;
   logic                    rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0]   rsp_tdata;
   logic                    rsp_tlast;

   dechirp_integrator tracker;
   int send_idle_pct  = 20;
   int recv_stall_pct = 79;
   int sent;

   quadratic_phase_dechirp_block_sum_core #(
      .MAX_BLOCK_SAMPLES(MAX_BLOCK)
   ) DUT (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      forever begin
         @(negedge clock);
         rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid === 1'b1 && rsp_tready) begin
         tracker.match_block_sum(rsp_tdata, rsp_tlast);
      end
   end

   // valid is left high on return so back-to-back requests need no toggle
   task automatic send_sample(input logic [SAMPLE_W-1:0] re, input logic [SAMPLE_W-1:0] im);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {im, re};
      do @(posedge clock); while (req_tready !== 1'b1);
      tracker.take_sample(re, im);
      @(negedge clock);
   endtask

   task automatic write_csr(input logic [CSR_ADDR_W-1:0] idx, input logic [CSR_DATA_W-1:0] data);
      csr_valid <= 1'b1;
      csr_addr  <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (csr_ready !== 1'b1);
      tracker.write_reg(idx, data);
      @(negedge clock);
      csr_valid <= 1'b0;
      @(negedge clock);
   endtask

   // hold requests until every block sum is back and the core has gone quiet
   task automatic settle();
      req_tvalid <= 1'b0;
      while (tracker.pending_sums.size() != 0) @(negedge clock);
      repeat (RUN_LATENCY) @(negedge clock);
   endtask

   function automatic logic [SAMPLE_W-1:0] pick_sample();
      case ($urandom_range(7))
         0:       return 16'h8000;
         1:       return 16'h7FFF;
         default: return SAMPLE_W'($urandom);
      endcase
   endfunction

   function automatic logic [RATE_W-1:0] pick_rate();
      logic [31:0] w;
      w = $urandom;
      case ($urandom_range(7))
         0:       return 32'h8000_0000;
         1:       return 32'h7FFF_FFFF;
         2:       return '0;
         3, 4:    return {{20{w[11]}}, w[11:0]};
         default: return w;
      endcase
   endfunction

   task automatic random_segment();
      csr_index_type r;
      logic [CSR_DATA_W-1:0] w;
      int n;
      settle();
      r = r.first();
      repeat (r.num()) begin
         if ($urandom_range(99) < 60) begin
            w = $urandom;
            case (r)
               CSR_SHIFT_RATE, CSR_DRIFT_RATE: w = pick_rate();
               CSR_START_INDEX: begin
                  if ($urandom_range(3) == 0) w[START_W-1:0] = '1;
               end
               CSR_BLOCK_LEN: begin
                  w[SPB_W-1:0] = ($urandom_range(15) == 0) ? '0 : SPB_W'($urandom_range(1, 12));
               end
               CSR_BLOCK_COUNT: begin
                  w[BCNT_W-1:0] = ($urandom_range(15) == 0) ? '0 : BCNT_W'($urandom_range(1, 4));
               end
               default: ;
            endcase
            write_csr(r, w);
         end
         r = r.next();
      end
      n = $urandom_range(1, tracker.eff_block_len() * tracker.eff_block_count() * 2 + 2);
      repeat (n) send_sample(pick_sample(), pick_sample());
      sent += n;
   endtask

   initial begin
      #100_000_000;
      $display("Verification failed");
      $finish;
   end

   initial begin
      tracker = new;
      tracker.power_on();
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // zero block length and zero block count both mean one
      write_csr(CSR_BLOCK_LEN, 32'hFFFF_E000);
      write_csr(CSR_BLOCK_COUNT, 32'hFFFF_0000);
      send_sample(16'h7FFF, 16'h7FFF);
      send_sample(16'h8000, 16'h8000);
      send_sample(16'h8000, 16'h7FFF);
      send_sample(16'h7FFF, 16'h8000);
      send_sample(16'h0000, 16'h0000);
      settle();

      // extreme rates, last start index, two blocks of two
      write_csr(CSR_SHIFT_RATE, 32'h4000_0000);
      write_csr(CSR_DRIFT_RATE, 32'h8000_0000);
      write_csr(CSR_START_INDEX, 32'hFFFF_FFFF);
      write_csr(CSR_BLOCK_LEN, 32'd2);
      write_csr(CSR_BLOCK_COUNT, 32'd2);
      send_sample(16'h7FFF, 16'h8000);
      send_sample(16'h8000, 16'h7FFF);
      send_sample(16'h7FFF, 16'h7FFF);
      send_sample(16'h8000, 16'h8000);

      // partial run cut short by a register write
      send_sample(16'h1234, 16'hEDCB);
      settle();
      write_csr(CSR_SHIFT_RATE, 32'hC000_0000);
      send_sample(16'h7FFF, 16'h0001);
      send_sample(16'hFFFF, 16'h8000);
      send_sample(16'h5555, 16'hAAAA);

      // unused index must leave the run alone
      settle();
      write_csr(CSR_UNUSED_INDEX, $urandom);
      send_sample(16'hAAAA, 16'h5555);

      while (sent < RANDOM_REQS) begin
         if (sent < RANDOM_REQS / 3) begin
            send_idle_pct  = 20;
            recv_stall_pct = 79;
         end else if (sent < 2 * RANDOM_REQS / 3) begin
            send_idle_pct  = 79;
            recv_stall_pct = 20;
         end else begin
            send_idle_pct  = 0;
            recv_stall_pct = 0;
         end
         random_segment();
      end

      // oversized block length clips to the maximum; full-scale samples push
      // the run power past its ceiling by the end of the run
      settle();
      write_csr(CSR_BLOCK_LEN, 32'hFFFF_FFFF);
      write_csr(CSR_BLOCK_COUNT, {16'hFFFF, 16'(SAT_BLOCKS)});
      write_csr(CSR_SHIFT_RATE, pick_rate());
      write_csr(CSR_DRIFT_RATE, pick_rate());
      write_csr(CSR_START_INDEX, $urandom);
      repeat (SAT_BLOCKS * MAX_BLOCK) begin
         send_sample($urandom_range(1) ? 16'h7FFF : 16'h8000,
                     $urandom_range(1) ? 16'h7FFF : 16'h8000);
      end
      settle();

      if (tracker.failures == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
